// ===== hw/rtl/dpf_pkg.sv =====
// shared types, constants and helpers of the download packet framer
package dpf_pkg;

  localparam int PACKET_BYTES_DEF = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_0_7   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_8_15  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_16_23 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_24_31 = 3'd5;

  localparam logic [31:0] FRAME_MAGIC = 32'h5859_5453;
  localparam logic [7:0]  CMD_START   = 8'd1;
  localparam logic [7:0]  CMD_CONT    = 8'd2;
  localparam logic [7:0]  OPT_DMA     = 8'd1;
  localparam logic [7:0]  CONT_TYPE   = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CONT
  } state_t;

  typedef struct packed {
    logic take;       // input beat accepted this cycle
    logic issue;      // launch the current packet word
    logic start_pkt;  // word belongs to a start packet
    logic final_word; // last word caused by this input beat
  } cmd_t;

  typedef struct packed {
    logic need_start;   // current byte opens an image
    logic need_cont;    // current byte closes a chunk
    logic cont_pending; // captured need_cont of the accepted byte
    logic word_last;    // word counter is on the packet's final word
    logic issue_ok;     // word pipeline can take a word
  } status_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== hw/rtl/dpf_if.sv =====
// valid/ready channels for image bytes and packet words
interface dpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;

  modport source (output valid, output image_byte, input ready);
  modport sink (input valid, input image_byte, output ready);
endinterface

interface dpf_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic [4:0]  word_index;
  logic        is_start_packet;
  logic        last_word;

  modport source (output valid, output packet_word, output word_index,
                  output is_start_packet, output last_word, input ready);
  modport sink (input valid, input packet_word, input word_index,
                input is_start_packet, input last_word, output ready);
endinterface

// ===== hw/rtl/download_packet_framer.sv =====
// Download packet framer top level: takes image bytes and emits packets as 32-bit words.
// A byte that opens an image, fills a chunk of PACKET_BYTES-8 payload bytes or ends the
// image is followed by one packet (PACKET_BYTES/4 words) or two, issued one word per
// cycle by the sequencer while the output side keeps up; the input stays blocked until
// the last word has been issued. Words pass through the buffer read stage, then the
// output register. Payload bytes wait in a simple dual-port buffer of (PACKET_BYTES-8)/4
// rows of four bytes. Configuration must be written only while no byte is being framed;
// the block itself does not enforce this.
module download_packet_framer #(
  parameter int PACKET_BYTES = dpf_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_data,
  dpf_byte_if.sink                       in_ch,
  dpf_word_if.source                     out_ch
);

  dpf_pkg::cmd_t    cmd;
  dpf_pkg::status_t sts;

  dpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpf_datapath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_ch.image_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.packet_word),
    .out_index (out_ch.word_index),
    .out_start (out_ch.is_start_packet),
    .out_last  (out_ch.last_word)
  );

endmodule

// ===== hw/rtl/dpf_ctrl.sv =====
// sequencer that walks start and continuation packets word by word
module dpf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dpf_pkg::status_t sts,
  output dpf_pkg::cmd_t    cmd
);

  dpf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.need_start) begin
            state_nxt = dpf_pkg::ST_START;
          end else if (sts.need_cont) begin
            state_nxt = dpf_pkg::ST_CONT;
          end
        end
      end
      dpf_pkg::ST_START: begin
        if (sts.issue_ok && sts.word_last) begin
          state_nxt = sts.cont_pending ? dpf_pkg::ST_CONT : dpf_pkg::ST_IDLE;
        end
      end
      dpf_pkg::ST_CONT: begin
        if (sts.issue_ok && sts.word_last) begin
          state_nxt = dpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.issue      = 1'b0;
    cmd.start_pkt  = 1'b0;
    cmd.final_word = 1'b0;
    unique case (state_r)
      dpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      dpf_pkg::ST_START: begin
        cmd.issue      = sts.issue_ok;
        cmd.start_pkt  = 1'b1;
        cmd.final_word = sts.word_last && !sts.cont_pending;
      end
      dpf_pkg::ST_CONT: begin
        cmd.issue      = sts.issue_ok;
        cmd.final_word = sts.word_last;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/dpf_datapath.sv =====
// config registers, chunk buffer, word builder and output stage
module dpf_datapath #(
  parameter int PACKET_BYTES = dpf_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     in_byte,
  input  dpf_pkg::cmd_t                  cmd,
  output dpf_pkg::status_t               sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_word,
  output logic [4:0]                     out_index,
  output logic                           out_start,
  output logic                           out_last
);

  localparam int PAYLOAD = PACKET_BYTES - 8;
  localparam int WORDS   = PACKET_BYTES / 4;
  localparam int ROWS    = PAYLOAD / 4;
  localparam int WORD_W  = $clog2(WORDS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int FILL_W  = $clog2(PAYLOAD + 1);

  // configuration
  logic [31:0] image_length_r;
  logic [31:0] load_address_r;
  logic [63:0] digest0_r, digest1_r, digest2_r, digest3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_length_r <= '0;
      load_address_r <= '0;
      digest0_r      <= '0;
      digest1_r      <= '0;
      digest2_r      <= '0;
      digest3_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpf_pkg::CFG_IMAGE_LENGTH: image_length_r <= cfg_data[31:0];
        dpf_pkg::CFG_LOAD_ADDRESS: load_address_r <= cfg_data[31:0];
        dpf_pkg::CFG_DIGEST_0_7:   digest0_r      <= cfg_data;
        dpf_pkg::CFG_DIGEST_8_15:  digest1_r      <= cfg_data;
        dpf_pkg::CFG_DIGEST_16_23: digest2_r      <= cfg_data;
        dpf_pkg::CFG_DIGEST_24_31: digest3_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte intake
  logic [31:0]       bytes_seen_r, bytes_seen_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [FILL_W-1:0] len_r;
  logic              end_r;
  logic              cont_pending_r;
  logic [23:0]       partial_r;
  logic              is_end, is_full;

  assign bytes_seen_nxt = bytes_seen_r + 32'd1;
  assign fill_inc       = fill_r + FILL_W'(1);
  assign is_end         = (bytes_seen_nxt == image_length_r);
  assign is_full        = (fill_inc == FILL_W'(PAYLOAD));
  assign fill_nxt       = (is_end || is_full) ? '0 : fill_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r   <= '0;
      fill_r         <= '0;
      cont_pending_r <= 1'b0;
    end else if (cmd.take) begin
      bytes_seen_r   <= is_end ? '0 : bytes_seen_nxt;
      fill_r         <= fill_nxt;
      cont_pending_r <= is_end || is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      len_r <= fill_inc;
      end_r <= is_end;
      case (fill_r[1:0])
        2'd0:    partial_r[7:0]   <= in_byte;
        2'd1:    partial_r[15:8]  <= in_byte;
        2'd2:    partial_r[23:16] <= in_byte;
        default: ;
      endcase
    end
  end

  // chunk buffer, four payload bytes per row, first byte in the low lane
  logic [31:0]      chunk_mem [ROWS];
  logic [31:0]      rdata_r;
  logic             mem_we, mem_re;
  logic [ROW_W-1:0] mem_waddr, mem_raddr;

  assign mem_we    = cmd.take && (fill_r[1:0] == 2'd3);
  assign mem_waddr = ROW_W'(fill_r >> 2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      chunk_mem[mem_waddr] <= {in_byte, partial_r};
    end
    if (mem_re) begin
      rdata_r <= chunk_mem[mem_raddr];
    end
  end

  // word counter
  logic [WORD_W-1:0] w_r;

  assign sts.word_last = (w_r == WORD_W'(WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else if (cmd.issue) begin
      w_r <= sts.word_last ? '0 : w_r + WORD_W'(1);
    end
  end

  // word builder
  logic [7:0][31:0] dig_words;
  logic [7:0]       w_ext;
  logic [2:0]       dk;
  logic [31:0]      start_word, cont_word, part_word;
  logic [WORD_W-1:0] row;
  logic [8:0]       row_ext, len_rows;
  logic             use_mem;
  logic [7:0]       pb0, pb1, pb2;

  assign dig_words = {digest0_r, digest1_r, digest2_r, digest3_r};
  assign w_ext     = 8'(w_r);
  assign dk        = 3'(w_ext - 8'd3);

  always_comb begin
    case (w_ext) inside
      8'd0:          start_word = dpf_pkg::bswap32(dpf_pkg::FRAME_MAGIC);
      8'd1:          start_word = {dpf_pkg::CMD_START, 8'd0, dpf_pkg::OPT_DMA, 8'd0};
      8'd2:          start_word = dpf_pkg::bswap32(image_length_r);
      [8'd3:8'd10]:  start_word = dig_words[3'd7 - dk];
      8'd11:         start_word = dpf_pkg::bswap32(load_address_r);
      default:       start_word = '0;
    endcase
  end

  assign row       = w_r - WORD_W'(2);
  assign row_ext   = 9'(row);
  assign len_rows  = 9'(len_r >> 2);
  assign mem_raddr = ROW_W'(row);

  // the row that holds the chunk's tail comes from the partial register
  assign pb0       = (len_r[1:0] > 2'd0) ? partial_r[7:0]   : 8'd0;
  assign pb1       = (len_r[1:0] > 2'd1) ? partial_r[15:8]  : 8'd0;
  assign pb2       = (len_r[1:0] > 2'd2) ? partial_r[23:16] : 8'd0;
  assign part_word = {pb0, pb1, pb2, 8'd0};

  always_comb begin
    use_mem = 1'b0;
    if (w_r == '0) begin
      cont_word = dpf_pkg::bswap32(dpf_pkg::FRAME_MAGIC);
    end else if (w_r == WORD_W'(1)) begin
      cont_word = {dpf_pkg::CMD_CONT, dpf_pkg::CONT_TYPE, 8'(len_r), 7'd0, end_r};
    end else if (row_ext < len_rows) begin
      cont_word = '0;
      use_mem   = 1'b1;
    end else if (row_ext == len_rows) begin
      cont_word = part_word;
    end else begin
      cont_word = '0;
    end
  end

  assign mem_re = cmd.issue && !cmd.start_pkt && use_mem;

  // stage after the buffer read, then the output register
  logic        s2_valid_r;
  logic [31:0] s2_word_r;
  logic        s2_use_mem_r;
  logic [4:0]  s2_index_r;
  logic        s2_start_r, s2_last_r;
  logic        s2_adv;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [4:0]  out_index_r;
  logic        out_start_r, out_last_r;

  assign s2_adv       = s2_valid_r && (!out_valid_r || out_ready);
  assign sts.issue_ok = !s2_valid_r || s2_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.issue) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s2_word_r    <= cmd.start_pkt ? start_word : cont_word;
      s2_use_mem_r <= !cmd.start_pkt && use_mem;
      s2_index_r   <= 5'(w_r);
      s2_start_r   <= cmd.start_pkt;
      s2_last_r    <= cmd.final_word;
    end
    if (s2_adv) begin
      out_word_r  <= s2_use_mem_r ? dpf_pkg::bswap32(rdata_r) : s2_word_r;
      out_index_r <= s2_index_r;
      out_start_r <= s2_start_r;
      out_last_r  <= s2_last_r;
    end
  end

  assign sts.need_start   = (bytes_seen_r == '0);
  assign sts.need_cont    = is_end || is_full;
  assign sts.cont_pending = cont_pending_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_index = out_index_r;
  assign out_start = out_start_r;
  assign out_last  = out_last_r;

endmodule
